### rtl/twa_pkg.sv
`default_nettype none

package twa_pkg;

   // Fixed field widths of the ports
   localparam int COORD_W = 24;
   localparam int TEXEL_W = 12;
   localparam int ELEM_W  = 26;
   localparam int BYTE_W  = 27;

   // Configuration register widths
   localparam int CSR_DIM_W  = 13;
   localparam int CSR_COMP_W = 3;
   localparam int CSR_BPC_W  = 2;
   localparam int CSR_MODE_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPONENTS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_CH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_S_MODE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_T_MODE  = 3'd5;

   // Wrap mode codes; the unused code behaves as repeat
   localparam logic [CSR_MODE_W-1:0] WRAP_REPEAT = 2'd0;
   localparam logic [CSR_MODE_W-1:0] WRAP_MIRROR = 2'd1;
   localparam logic [CSR_MODE_W-1:0] WRAP_CLAMP  = 2'd2;

   // Geometry
   localparam int MAX_DIM   = 4096;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = $clog2(MAX_DIM);       // texel index, size - 1
   localparam int SIZE_W    = IDX_W + 1;             // size itself
   localparam int PER_W     = SIZE_W + 1;            // period up to 2 * size
   localparam int PROD_W    = COORD_W + IDX_W;       // magnitude * (size - 1)
   localparam int Q_W       = PROD_W - FRAC_BITS;    // scaled index magnitude
   localparam int DIV_STEP  = 4;                     // dividend bits shifted in per stage
   localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;
   localparam int Q_PAD     = DIV_STAGES * DIV_STEP;
   localparam int AXIS_STAGES = DIV_STAGES + 3;
   localparam int ADDR_STAGES = 2;
   localparam int N_STAGES  = AXIS_STAGES + ADDR_STAGES;
   localparam int YW_W      = IDX_W + SIZE_W;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [IDX_W-1:0]  size_m1;
      logic [PER_W-1:0]  period;
      logic              mirror;
      logic              clamp;
   } axis_cfg_type;

   typedef struct packed {
      logic [SIZE_W-1:0]     width;
      logic [CSR_COMP_W-1:0] comp;
      logic                  bpc2;
   } addr_cfg_type;

endpackage

`default_nettype wire

### rtl/twa_axis.sv
`default_nettype none

module twa_axis
   import twa_pkg::*;
(
   input  wire logic                      clock,
   input  wire axis_cfg_type              cfg,
   input  wire logic [AXIS_STAGES-1:0]    en,
   input  wire logic signed [COORD_W-1:0] coord,
   output logic [IDX_W-1:0]               texel
);

   // Stage 0: sign and magnitude
   logic               neg0_ff;
   logic [COORD_W-1:0] mag0_ff;
   // Stage 1: scaled magnitude
   logic               neg1_ff;
   logic [Q_PAD-1:0]   m1_ff;
   logic [PROD_W-1:0]  prod_in;
   // Remainder stages
   logic [PER_W-1:0]   rem_ff [DIV_STAGES];
   logic [PER_W-1:0]   rem_in [DIV_STAGES];
   logic [Q_PAD-1:0]   md_ff  [DIV_STAGES];
   logic               negd_ff[DIV_STAGES];
   // Final wrap
   logic [IDX_W-1:0]   texel_ff;
   logic [IDX_W-1:0]   texel_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg0_ff <= coord[COORD_W-1];
         mag0_ff <= coord[COORD_W-1] ? (~coord + 1'b1) : coord;
      end
   end

   assign prod_in = PROD_W'(mag0_ff) * PROD_W'(cfg.size_m1);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         neg1_ff <= neg0_ff;
         m1_ff   <= Q_PAD'(prod_in >> FRAC_BITS);
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [PER_W-1:0] rem_prev;
      logic [Q_PAD-1:0] m_prev;
      logic             neg_prev;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign m_prev   = m1_ff;
         assign neg_prev = neg1_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign m_prev   = md_ff[k-1];
         assign neg_prev = negd_ff[k-1];
      end

      // shift in DIV_STEP dividend bits in turn, subtracting the period where it fits
      always_comb begin
         logic [PER_W:0] r;
         r = {1'b0, rem_prev};
         for (int b = 0; b < DIV_STEP; b++) begin
            r = {r[PER_W-1:0], m_prev[Q_PAD-1-DIV_STEP*k-b]};
            if (r >= {1'b0, cfg.period}) begin
               r = r - {1'b0, cfg.period};
            end
         end
         rem_in[k] = r[PER_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en[2+k]) begin
            rem_ff[k]  <= rem_in[k];
            md_ff[k]   <= m_prev;
            negd_ff[k] <= neg_prev;
         end
      end
   end

   always_comb begin
      logic [PER_W-1:0] rem;
      logic [Q_PAD-1:0] m;
      logic             neg;
      logic [PER_W-1:0] r;
      rem = rem_ff[DIV_STAGES-1];
      m   = md_ff[DIV_STAGES-1];
      neg = negd_ff[DIV_STAGES-1];
      // negative index: fold into the period
      r = (neg && (rem != '0)) ? (cfg.period - rem) : rem;
      // second half of a mirrored period runs backwards
      if (cfg.mirror && (r >= PER_W'(cfg.size))) begin
         r = cfg.period - 1'b1 - r;
      end
      if (cfg.clamp) begin
         if (neg) begin
            texel_in = '0;
         end else if (m >= Q_PAD'(cfg.size)) begin
            texel_in = cfg.size_m1;
         end else begin
            texel_in = m[IDX_W-1:0];
         end
      end else begin
         texel_in = r[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[AXIS_STAGES-1]) begin
         texel_ff <= texel_in;
      end
   end

   assign texel = texel_ff;

endmodule

`default_nettype wire

### rtl/twa_addr.sv
`default_nettype none

module twa_addr
   import twa_pkg::*;
(
   input  wire logic                   clock,
   input  wire addr_cfg_type           cfg,
   input  wire logic [ADDR_STAGES-1:0] en,
   input  wire logic [IDX_W-1:0]       texel_x,
   input  wire logic [IDX_W-1:0]       texel_y,
   output logic [TEXEL_W-1:0]          out_x,
   output logic [TEXEL_W-1:0]          out_y,
   output logic [ELEM_W-1:0]           element_index,
   output logic [BYTE_W-1:0]           byte_addr
);

   localparam int SUM_W  = YW_W + 1;
   localparam int FULL_W = SUM_W + CSR_COMP_W;

   logic [IDX_W-1:0]   xa_ff;
   logic [IDX_W-1:0]   ya_ff;
   logic [YW_W-1:0]    yw_ff;
   logic [IDX_W-1:0]   xb_ff;
   logic [IDX_W-1:0]   yb_ff;
   logic [ELEM_W-1:0]  elem_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [FULL_W-1:0]  full_in;

   // row offset
   always_ff @(posedge clock) begin
      if (en[0]) begin
         xa_ff <= texel_x;
         ya_ff <= texel_y;
         yw_ff <= YW_W'(texel_y) * YW_W'(cfg.width);
      end
   end

   assign full_in = FULL_W'(SUM_W'(yw_ff) + SUM_W'(xa_ff)) * FULL_W'(cfg.comp);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         xb_ff   <= xa_ff;
         yb_ff   <= ya_ff;
         elem_ff <= ELEM_W'(full_in);
         byte_ff <= cfg.bpc2 ? BYTE_W'({full_in, 1'b0}) : BYTE_W'(full_in);
      end
   end

   assign out_x         = TEXEL_W'(xb_ff);
   assign out_y         = TEXEL_W'(yb_ff);
   assign element_index = elem_ff;
   assign byte_addr     = byte_ff;

endmodule

`default_nettype wire

### rtl/texture_wrap_address_unit.sv
`default_nettype none

// Texture wrap addressing unit.
// Request channel (req_): one signed Q8.16 coordinate pair per transaction.
// Response channel (rsp_): wrapped texel x and y, element index and byte address.
// Both channels move a transaction on a clock edge with valid high and stall low.
// Register port (csr_): index and write data, always ready; write it only while
// no transaction is in flight. Registers: width, height, components, bytes per
// channel, horizontal and vertical wrap mode.
// Throughput: one transaction per cycle while the response is not stalled.
// Depth is set by the sign/magnitude stage, the scaling multiplier, the
// remainder pipeline, which retires four index bits per stage over five stages,
// the final wrap stage and two address stages.
// A stalled response holds every stage behind it; empty stages still fill, so
// requests keep flowing until the pipeline is full.
// Reset (synchronous): drop all transactions in flight, load the register
// defaults (1 x 1 texels, four components, one byte per channel, repeat).
module texture_wrap_address_unit
   import twa_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [COORD_W-1:0] req_s_coord,
   input  wire logic signed [COORD_W-1:0] req_t_coord,
   // response
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [TEXEL_W-1:0]             rsp_texel_x,
   output logic [TEXEL_W-1:0]             rsp_texel_y,
   output logic [ELEM_W-1:0]              rsp_element_index,
   output logic [BYTE_W-1:0]              rsp_byte_addr,
   // registers
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata
);

   logic [CSR_DIM_W-1:0]  width_ff;
   logic [CSR_DIM_W-1:0]  height_ff;
   logic [CSR_COMP_W-1:0] comp_ff;
   logic [CSR_BPC_W-1:0]  bpc_ff;
   logic [CSR_MODE_W-1:0] mode_s_ff;
   logic [CSR_MODE_W-1:0] mode_t_ff;

   logic [SIZE_W-1:0]     width_lim;
   logic [SIZE_W-1:0]     height_lim;
   axis_cfg_type          cfg_s;
   axis_cfg_type          cfg_t;
   addr_cfg_type          cfg_a;

   logic [N_STAGES-1:0]   valid_ff;
   logic [N_STAGES:0]     en;

   logic [IDX_W-1:0]      tex_x;
   logic [IDX_W-1:0]      tex_y;

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DIM_W'(1);
         height_ff <= CSR_DIM_W'(1);
         comp_ff   <= CSR_COMP_W'(4);
         bpc_ff    <= CSR_BPC_W'(1);
         mode_s_ff <= WRAP_REPEAT;
         mode_t_ff <= WRAP_REPEAT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_COMPONENTS:   comp_ff   <= csr_wdata[CSR_COMP_W-1:0];
            CSR_BYTES_PER_CH: bpc_ff    <= csr_wdata[CSR_BPC_W-1:0];
            CSR_WRAP_S_MODE:  mode_s_ff <= csr_wdata[CSR_MODE_W-1:0];
            CSR_WRAP_T_MODE:  mode_t_ff <= csr_wdata[CSR_MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // Limit sizes to 1..MAX_DIM and components to 1..4
   always_comb begin
      if (width_ff == '0) begin
         width_lim = SIZE_W'(1);
      end else if (int'(width_ff) > MAX_DIM) begin
         width_lim = SIZE_W'(MAX_DIM);
      end else begin
         width_lim = SIZE_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_lim = SIZE_W'(1);
      end else if (int'(height_ff) > MAX_DIM) begin
         height_lim = SIZE_W'(MAX_DIM);
      end else begin
         height_lim = SIZE_W'(height_ff);
      end
   end

   always_comb begin
      cfg_s.size    = width_lim;
      cfg_s.size_m1 = IDX_W'(width_lim - 1'b1);
      cfg_s.mirror  = (mode_s_ff == WRAP_MIRROR);
      cfg_s.clamp   = (mode_s_ff == WRAP_CLAMP);
      cfg_s.period  = cfg_s.mirror ? {width_lim, 1'b0} : PER_W'(width_lim);

      cfg_t.size    = height_lim;
      cfg_t.size_m1 = IDX_W'(height_lim - 1'b1);
      cfg_t.mirror  = (mode_t_ff == WRAP_MIRROR);
      cfg_t.clamp   = (mode_t_ff == WRAP_CLAMP);
      cfg_t.period  = cfg_t.mirror ? {height_lim, 1'b0} : PER_W'(height_lim);

      cfg_a.width = width_lim;
      if (comp_ff == '0) begin
         cfg_a.comp = CSR_COMP_W'(1);
      end else if (comp_ff > CSR_COMP_W'(4)) begin
         cfg_a.comp = CSR_COMP_W'(4);
      end else begin
         cfg_a.comp = comp_ff;
      end
      cfg_a.bpc2 = (bpc_ff >= CSR_BPC_W'(2));
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or the stage
   // ahead of it loads, so bubbles close up behind a stalled response.
   // ---------------------------------------------------------------
   always_comb begin
      en[N_STAGES] = !rsp_stall;
      for (int k = N_STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < N_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign rsp_valid = valid_ff[N_STAGES-1];

   // ---------------------------------------------------------------
   // Datapath: scale and wrap each axis, then form the address
   // ---------------------------------------------------------------
   twa_axis u_axis_s (
      .clock (clock),
      .cfg   (cfg_s),
      .en    (en[AXIS_STAGES-1:0]),
      .coord (req_s_coord),
      .texel (tex_x)
   );

   twa_axis u_axis_t (
      .clock (clock),
      .cfg   (cfg_t),
      .en    (en[AXIS_STAGES-1:0]),
      .coord (req_t_coord),
      .texel (tex_y)
   );

   twa_addr u_addr (
      .clock         (clock),
      .cfg           (cfg_a),
      .en            (en[N_STAGES-1:AXIS_STAGES]),
      .texel_x       (tex_x),
      .texel_y       (tex_y),
      .out_x         (rsp_texel_x),
      .out_y         (rsp_texel_y),
      .element_index (rsp_element_index),
      .byte_addr     (rsp_byte_addr)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // Back-pressure only reaches the request side once every stage is full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("request stalled with an empty stage in the pipeline");

   // An accepted request occupies the first stage on the next edge
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request lost at pipeline entry");

   // Reset leaves the pipeline empty
   assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("transaction in flight after reset");

endmodule

`default_nettype wire
